// File: sv/mi3_pkg.sv
// Package for the 3x3 matrix inverse block: fixed widths, payload types and the
// queue entry that passes from the front end to the divider pipeline.
// No dependencies.
package mi3_pkg;

   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int CW        = 2 * ELEM_W + 1;
   localparam int CMW       = 2 * ELEM_W;
   localparam int DW        = 3 * ELEM_W + 1;
   localparam int DMW       = 3 * ELEM_W;
   localparam int THR_W     = ELEM_W - 1;
   localparam int NUM_LANES = 9;
   localparam int NUM_PROD  = 18;
   localparam int QDEPTH    = 2;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [CW-1:0]     cof_type;
   typedef logic signed [DW-1:0]     det_type;

   typedef struct packed {
      cof_type [NUM_LANES-1:0] cof;
      logic [DMW-1:0]          det_mag;
      logic                    det_neg;
      logic                    sing;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: sv/mi3_front.sv
// Front end: registers an accepted matrix, forms the cofactors and the determinant
// and classifies the item as singular or not. Depends on mi3_pkg.
module mi3_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  mi3_pkg::elem_type          in_elem [mi3_pkg::NUM_LANES],
   input  logic [mi3_pkg::THR_W-1:0]  thr,
   output logic                       push,
   output mi3_pkg::job_type           job
);
   import mi3_pkg::*;

   localparam int PA [NUM_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
   localparam int PB [NUM_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};
   localparam int DC [3] = '{0, 3, 6};

   logic [5:0]   vld_ff;
   elem_type     el_ff [NUM_LANES];
   prod_type     prod_ff [NUM_PROD], prod_in [NUM_PROD];
   elem_type     a1_ff [3], a2_ff [3];
   cof_type      cof2_ff [NUM_LANES], cof2_in [NUM_LANES];
   cof_type      cof3_ff [NUM_LANES], cof4_ff [NUM_LANES], cof5_ff [NUM_LANES];
   logic signed [CW-1:0] plo_ff [3], plo_in [3], phi_ff [3], phi_in [3];
   det_type      term_ff [3], term_in [3];
   det_type      det_ff, det_in;
   logic [DMW-1:0] mag;

   always_comb begin
      for (int i = 0; i < NUM_PROD; i++) begin
         prod_in[i] = el_ff[PA[i]] * el_ff[PB[i]];
      end
      for (int i = 0; i < NUM_LANES; i++) begin
         cof2_in[i] = CW'(prod_ff[2*i]) - CW'(prod_ff[2*i+1]);
      end
      for (int j = 0; j < 3; j++) begin
         plo_in[j]  = a2_ff[j] * $signed({1'b0, cof2_ff[DC[j]][ELEM_W-1:0]});
         phi_in[j]  = a2_ff[j] * $signed(cof2_ff[DC[j]][CW-1:ELEM_W]);
         term_in[j] = (DW'(phi_ff[j]) <<< ELEM_W) + DW'(plo_ff[j]);
      end
      det_in = term_ff[0] + term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (in_valid) begin
            el_ff <= in_elem;
         end
         prod_ff <= prod_in;
         a1_ff   <= el_ff[0:2];
         a2_ff   <= a1_ff;
         cof2_ff <= cof2_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         cof3_ff <= cof2_ff;
         term_ff <= term_in;
         cof4_ff <= cof3_ff;
         det_ff  <= det_in;
         cof5_ff <= cof4_ff;
      end
   end

   always_comb begin
      mag = det_ff[DW-1] ? DMW'(-det_ff) : DMW'(det_ff);
      for (int i = 0; i < NUM_LANES; i++) begin
         job.cof[i] = cof5_ff[i];
      end
      job.det_mag = mag;
      job.det_neg = det_ff[DW-1];
      job.sing    = mag <= (DMW'(thr) << (2 * FRAC_BITS));
      push        = vld_ff[5] && advance;
   end

endmodule

// File: sv/mi3_queue.sv
// Short queue between the front end and the divider pipeline.
// Depends on mi3_pkg.
module mi3_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mi3_pkg::job_type   push_job,
   output logic               pop_valid,
   output mi3_pkg::job_type   pop_job,
   output mi3_pkg::qstat_type stat
);
   import mi3_pkg::*;

   localparam int QAW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNTW = $clog2(QDEPTH + 1);

   job_type         mem_ff [QDEPTH];
   logic [QAW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            pop;

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == CNTW'(QDEPTH));
      pop        = !stat.empty;
      pop_valid  = pop;
      pop_job    = mem_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/mi3_back.sv
// Back end: nine pipelined restoring dividers, one quotient bit per stage, then
// rounding, sign and saturation into the result register. Depends on mi3_pkg.
module mi3_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  mi3_pkg::job_type  job,
   output logic              rsp_valid,
   output mi3_pkg::elem_type rsp_inv [mi3_pkg::NUM_LANES],
   output logic              rsp_singular
);
   import mi3_pkg::*;

   localparam int NMAX = (CMW + 2 * FRAC_BITS > DMW) ? CMW + 2 * FRAC_BITS : DMW;
   localparam int NW   = NMAX + 2;
   localparam int RW   = NW + ELEM_W;
   localparam int NST  = ELEM_W;

   localparam logic [ELEM_W-1:0] MAXV = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] MINV = {1'b1, {(ELEM_W-1){1'b0}}};
   localparam logic [ELEM_W-1:0] HALF = {1'b1, {(ELEM_W-1){1'b0}}};

   logic [NST:0]      vld_ff;
   logic [RW-1:0]     rem_ff [NST+1][NUM_LANES], rem_in [NST+1][NUM_LANES];
   logic [ELEM_W-1:0] quo_ff [NST+1][NUM_LANES], quo_in [NST+1][NUM_LANES];
   logic              neg_ff [NST+1][NUM_LANES], neg_in [NST+1][NUM_LANES];
   logic              sat_ff [NST+1][NUM_LANES], sat_in [NST+1][NUM_LANES];
   logic [NW-1:0]     dv_ff [NST+1], dv_in [NST+1];
   logic              sing_ff [NST+1], sing_in [NST+1];
   logic              out_vld_ff;
   elem_type          res_ff [NUM_LANES], res_in [NUM_LANES];
   logic              out_sing_ff;

   always_comb begin
      logic [CMW-1:0]    cmag;
      logic [NW-1:0]     nn;
      logic [NW-1:0]     dd;
      logic [RW-1:0]     tr;
      logic [ELEM_W-1:0] q;
      logic              ng;
      dd = job.sing ? (NW'(1) << FRAC_BITS) : NW'(job.det_mag);
      dv_in[0]   = dd << 1;
      sing_in[0] = job.sing;
      for (int i = 0; i < NUM_LANES; i++) begin
         cmag = job.cof[i][CW-1] ? CMW'(-job.cof[i]) : CMW'(job.cof[i]);
         nn   = job.sing ? NW'(cmag) : (NW'(cmag) << (2 * FRAC_BITS));
         rem_in[0][i] = RW'(nn << 1) + RW'(dd);
         sat_in[0][i] = rem_in[0][i] >= (RW'(dv_in[0]) << ELEM_W);
         neg_in[0][i] = job.cof[i][CW-1] ^ (!job.sing && job.det_neg);
         quo_in[0][i] = '0;
      end
      for (int s = 0; s < NST; s++) begin
         dv_in[s+1]   = dv_ff[s];
         sing_in[s+1] = sing_ff[s];
         tr = RW'(dv_ff[s]) << (ELEM_W - 1 - s);
         for (int i = 0; i < NUM_LANES; i++) begin
            neg_in[s+1][i] = neg_ff[s][i];
            sat_in[s+1][i] = sat_ff[s][i];
            if (rem_ff[s][i] >= tr) begin
               rem_in[s+1][i] = rem_ff[s][i] - tr;
               quo_in[s+1][i] = quo_ff[s][i] | (ELEM_W'(1) << (ELEM_W - 1 - s));
            end else begin
               rem_in[s+1][i] = rem_ff[s][i];
               quo_in[s+1][i] = quo_ff[s][i];
            end
         end
      end
      for (int i = 0; i < NUM_LANES; i++) begin
         q  = quo_ff[NST][i];
         ng = neg_ff[NST][i];
         if (sat_ff[NST][i]) begin
            res_in[i] = ng ? MINV : MAXV;
         end else if (!ng && q[ELEM_W-1]) begin
            res_in[i] = MAXV;
         end else if (ng && (q > HALF)) begin
            res_in[i] = MINV;
         end else begin
            res_in[i] = ng ? -q : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[NST-1:0], job_valid};
         out_vld_ff <= vld_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      dv_ff       <= dv_in;
      sing_ff     <= sing_in;
      res_ff      <= res_in;
      out_sing_ff <= sing_ff[NST];
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_inv      = res_ff;
   assign rsp_singular = out_sing_ff;

endmodule

// File: sv/matrix_inverse_3x3_top.sv
// Top level of the 3x3 matrix inverse: threshold register, front end, queue and
// divider back end. Depends on mi3_pkg, mi3_front, mi3_queue and mi3_back.
//
//   Channel   Ports                               Handshake
//   request   start, busy, req_elem_*             taken when start and not busy
//   response  rsp_valid, rsp_inv_*, rsp_singular  one-cycle strobe, no back pressure
//   config    csr_valid, csr_ready, csr_data      written when valid and ready
//
// One matrix is accepted per cycle while busy is low; its result strobe follows the
// front end registers, the queue and one divider stage per result bit, then the
// result register. Reset is synchronous and clears all valid state and sets the
// threshold to 1. The queue drains every cycle, so busy stays low in operation.
module matrix_inverse_3x3_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  mi3_pkg::elem_type         req_elem_0_0,
   input  mi3_pkg::elem_type         req_elem_0_1,
   input  mi3_pkg::elem_type         req_elem_0_2,
   input  mi3_pkg::elem_type         req_elem_1_0,
   input  mi3_pkg::elem_type         req_elem_1_1,
   input  mi3_pkg::elem_type         req_elem_1_2,
   input  mi3_pkg::elem_type         req_elem_2_0,
   input  mi3_pkg::elem_type         req_elem_2_1,
   input  mi3_pkg::elem_type         req_elem_2_2,
   output logic                      rsp_valid,
   output mi3_pkg::elem_type         rsp_inv_0_0,
   output mi3_pkg::elem_type         rsp_inv_0_1,
   output mi3_pkg::elem_type         rsp_inv_0_2,
   output mi3_pkg::elem_type         rsp_inv_1_0,
   output mi3_pkg::elem_type         rsp_inv_1_1,
   output mi3_pkg::elem_type         rsp_inv_1_2,
   output mi3_pkg::elem_type         rsp_inv_2_0,
   output mi3_pkg::elem_type         rsp_inv_2_1,
   output mi3_pkg::elem_type         rsp_inv_2_2,
   output logic                      rsp_singular,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mi3_pkg::THR_W-1:0] csr_data
);
   import mi3_pkg::*;

   logic [THR_W-1:0] thr_ff;
   elem_type         in_elem [NUM_LANES];
   elem_type         res [NUM_LANES];
   qstat_type        qstat;
   logic             accept, push, pop_valid;
   job_type          push_job, pop_job;

   assign csr_ready = 1'b1;
   assign busy      = qstat.full;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   assign in_elem = '{req_elem_0_0, req_elem_0_1, req_elem_0_2,
                      req_elem_1_0, req_elem_1_1, req_elem_1_2,
                      req_elem_2_0, req_elem_2_1, req_elem_2_2};

   mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (!qstat.full),
      .in_valid (accept),
      .in_elem  (in_elem),
      .thr      (thr_ff),
      .push     (push),
      .job      (push_job)
   );

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .stat      (qstat)
   );

   mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (pop_valid),
      .job          (pop_job),
      .rsp_valid    (rsp_valid),
      .rsp_inv      (res),
      .rsp_singular (rsp_singular)
   );

   assign rsp_inv_0_0 = res[0];
   assign rsp_inv_0_1 = res[1];
   assign rsp_inv_0_2 = res[2];
   assign rsp_inv_1_0 = res[3];
   assign rsp_inv_1_1 = res[4];
   assign rsp_inv_1_2 = res[5];
   assign rsp_inv_2_0 = res[6];
   assign rsp_inv_2_1 = res[7];
   assign rsp_inv_2_2 = res[8];

endmodule

// File: sv/mi3_checker.sv
// Port-level checker for the 3x3 matrix inverse and its bind to the top level.
// Depends on mi3_pkg and matrix_inverse_3x3_top.
module mi3_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import mi3_pkg::*;

   localparam int LATENCY = 9 + ELEM_W;

   a_busy_low: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy rose although the queue drains every cycle");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result at the expected cycle");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching accepted transaction");

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// File: tb/testbench.sv
// Self-checking testbench for matrix_inverse_3x3_top: drives 3x3 Q16.16 matrices,
// predicts each adjugate-based inverse with exact wide arithmetic and checks every result.
// Depends on mi3_pkg and the matrix_inverse_3x3_top RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mi3_pkg::*;

   typedef logic signed [255:0] wide_t;
   typedef elem_type [8:0] matrix_t;
   typedef struct packed {
      elem_type [8:0] inv;
      logic           sing;
   } inverse_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   elem_type req_elem [9] = '{default: '0};
   logic rsp_valid;
   elem_type rsp_inv [9];
   logic rsp_singular;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THR_W-1:0] csr_data = '0;

   matrix_t pending_matrices[$];
   inverse_t expected_inverses[$];
   logic [THR_W-1:0] det_threshold = 1;
   bit failed = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   matrix_inverse_3x3_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_elem_0_0(req_elem[0]), .req_elem_0_1(req_elem[1]), .req_elem_0_2(req_elem[2]),
      .req_elem_1_0(req_elem[3]), .req_elem_1_1(req_elem[4]), .req_elem_1_2(req_elem[5]),
      .req_elem_2_0(req_elem[6]), .req_elem_2_1(req_elem[7]), .req_elem_2_2(req_elem[8]),
      .rsp_valid(rsp_valid),
      .rsp_inv_0_0(rsp_inv[0]), .rsp_inv_0_1(rsp_inv[1]), .rsp_inv_0_2(rsp_inv[2]),
      .rsp_inv_1_0(rsp_inv[3]), .rsp_inv_1_1(rsp_inv[4]), .rsp_inv_1_2(rsp_inv[5]),
      .rsp_inv_2_0(rsp_inv[6]), .rsp_inv_2_1(rsp_inv[7]), .rsp_inv_2_2(rsp_inv[8]),
      .rsp_singular(rsp_singular),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic elem_type div_round_sat(wide_t num, wide_t den);
      wide_t n, d, q, r, lim;
      logic neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n - q * d;
      if ((r <<< 1) >= d) q = q + 1;
      lim = 1;
      lim = lim <<< (ELEM_W - 1);
      if (neg) begin
         if (q > lim) return {1'b1, {(ELEM_W-1){1'b0}}};
         q = -q;
         return q[ELEM_W-1:0];
      end
      if (q >= lim) return {1'b0, {(ELEM_W-1){1'b1}}};
      return q[ELEM_W-1:0];
   endfunction

   function automatic inverse_t invert_matrix(matrix_t m, logic [THR_W-1:0] thr_reg);
      wide_t a [9];
      wide_t cof [9];
      wide_t det, det_mag, thr, den, num;
      inverse_t res;
      for (int i = 0; i < 9; i++) a[i] = m[i];
      cof[0] = a[4] * a[8] - a[5] * a[7];
      cof[1] = a[2] * a[7] - a[1] * a[8];
      cof[2] = a[1] * a[5] - a[2] * a[4];
      cof[3] = a[5] * a[6] - a[3] * a[8];
      cof[4] = a[0] * a[8] - a[2] * a[6];
      cof[5] = a[2] * a[3] - a[0] * a[5];
      cof[6] = a[3] * a[7] - a[4] * a[6];
      cof[7] = a[1] * a[6] - a[0] * a[7];
      cof[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
      det_mag = (det < 0) ? -det : det;
      thr = {225'b0, thr_reg};
      thr = thr <<< 32;
      res.sing = det_mag <= thr;
      den = 1;
      den = res.sing ? (den <<< 16) : det;
      for (int i = 0; i < 9; i++) begin
         num = res.sing ? cof[i] : (cof[i] <<< 32);
         res.inv[i] = div_round_sat(num, den);
      end
      return res;
   endfunction

   function automatic elem_type rand_elem(int kind);
      case (kind)
         0: return elem_type'($urandom);
         1: return elem_type'(int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
         default: return elem_type'(int'($urandom_range(0, 16)) - 8);
      endcase
   endfunction

   function automatic matrix_t rand_matrix();
      matrix_t m;
      int kind;
      int sel;
      sel = $urandom_range(0, 9);
      kind = (sel < 3) ? 0 : (sel < 8) ? 1 : 2;
      for (int i = 0; i < 9; i++) m[i] = rand_elem(kind);
      if (sel == 9) begin
         for (int i = 0; i < 3; i++) m[6+i] = m[i] + m[3+i];
      end
      return m;
   endfunction

   task automatic write_threshold(logic [THR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      det_threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_matrices.size() != 0 || expected_inverses.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || pending_matrices.size() == 0) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else begin
         start <= 1'b1;
         for (int i = 0; i < 9; i++) req_elem[i] <= pending_matrices[0][i];
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      inverse_t want;
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            $error("unexpected result transaction");
            failed = 1'b1;
         end else begin
            want = expected_inverses.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (rsp_inv[i] !== want.inv[i]) begin
                  $error("inv_%0d_%0d expected %h actual %h", i / 3, i % 3,
                         want.inv[i], rsp_inv[i]);
                  failed = 1'b1;
               end
            end
            if (rsp_singular !== want.sing) begin
               $error("singular expected %b actual %b", want.sing, rsp_singular);
               failed = 1'b1;
            end
         end
      end
      if (!reset && start && !busy) begin
         expected_inverses.push_back(invert_matrix(pending_matrices.pop_front(),
                                                   det_threshold));
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      matrix_t m;
      logic [THR_W-1:0] thresholds [5];
      elem_type one;
      one = 32'sh1_0000;
      thresholds = '{31'h0, 31'h7fff_ffff, 31'h0, 31'h1_0000, 31'h1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      m = '0; m[0] = one; m[4] = one; m[8] = one;
      pending_matrices.push_back(m);
      m = '0;
      pending_matrices.push_back(m);
      m = {9{32'sh7fff_ffff}};
      pending_matrices.push_back(m);
      m = {9{32'sh8000_0000}};
      pending_matrices.push_back(m);
      m = '0; m[0] = -one; m[4] = one; m[8] = one;
      pending_matrices.push_back(m);
      m = '0; m[0] = 1; m[4] = 1; m[8] = 1;
      pending_matrices.push_back(m);
      m = '0; m[0] = 32'sh8000_0000; m[4] = 32'sh7fff_ffff; m[8] = 32'sh8000_0000;
      pending_matrices.push_back(m);
      m = '0; m[0] = 32'sh100; m[4] = 32'sh100; m[8] = 32'sh100;
      pending_matrices.push_back(m);
      m = '0; m[0] = 32'sh1_0000; m[1] = 32'sh2_0000; m[2] = 32'sh3_0000;
      m[3] = 32'sh0; m[4] = 32'sh1_0000; m[5] = 32'sh4_0000;
      m[6] = 32'sh5_0000; m[7] = 32'sh6_0000; m[8] = 32'sh0;
      pending_matrices.push_back(m);
      m = '0; m[2] = one; m[4] = -one; m[6] = 32'sh8000;
      pending_matrices.push_back(m);
      drain();

      for (int p = 0; p < 5; p++) begin
         if (p == 4) begin
            write_threshold(31'($urandom_range(0, 32'h7fff_ffff)));
         end else begin
            write_threshold(thresholds[p]);
         end
         for (int k = 0; k < 200; k++) pending_matrices.push_back(rand_matrix());
         drain();
      end
      write_threshold(thresholds[4]);
      m = '0; m[0] = 1; m[4] = 1; m[8] = 1;
      pending_matrices.push_back(m);
      m[0] = -1;
      pending_matrices.push_back(m);
      m[0] = 2;
      pending_matrices.push_back(m);
      drain();

      if (!failed) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// File: matrix_inverse_3x3_top.f
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_queue.sv
sv/mi3_back.sv
sv/matrix_inverse_3x3_top.sv
sv/mi3_checker.sv
tb/testbench.sv
